### src/llgh_pkg.sv
// ----------------------------------------------------------------------------
// llgh_pkg
// Types, constants and helper functions of the loss gradient/hessian block.
// ----------------------------------------------------------------------------
package llgh_pkg;

  localparam int SCORE_W = 32;
  localparam int FRAC_W  = 16;
  localparam int HESS_W  = 18;
  localparam int EXP_STEPS = 16;
  localparam int P_BITS  = 30;   // quotient bits of e/(1+e) in Q30
  localparam int R_BITS  = 17;   // quotient bits of the rounded Q16 divides

  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [30:0] Q30_ONE   = 31'h4000_0000;

  localparam logic [31:0] CFG_ADDR_LOSS_MODE = 32'd0;

  typedef enum logic [1:0] {
    LOSS_LOGISTIC = 2'd0,
    LOSS_SQERR    = 2'd1,
    LOSS_SQHINGE  = 2'd2,
    LOSS_NONE     = 2'd3
  } loss_mode_e;

  typedef struct packed {
    loss_mode_e         mode;
    logic               pos;
    logic               xneg;
    logic signed [31:0] g_alt;
    logic [HESS_W-1:0]  h_alt;
    logic               sat_alt;
  } ctl_t;

  typedef struct packed {
    logic        ez;
    logic [4:0]  n;
    logic [15:0] fb;
    logic [30:0] m;
  } exp_t;

  typedef struct packed {
    logic [31:0]       d;
    logic [31:0]       pr;
    logic [P_BITS-1:0] pq;
    logic [31:0]       rr;
    logic [R_BITS-1:0] rq;
    logic [R_BITS-1:0] rlo;
  } div_t;

  typedef struct packed {
    logic [31:0]       d;
    logic [31:0]       rem;
    logic [R_BITS-1:0] q;
    logic [R_BITS-1:0] lo;
    logic [R_BITS-1:0] r;
  } hdiv_t;

  // one restoring division step: {quotient bit, new remainder}
  function automatic logic [32:0] div_step(logic [31:0] rem, logic nb, logic [31:0] d);
    logic [32:0] t;
    t = {rem, nb};
    if (t >= {1'b0, d}) begin
      return {1'b1, 32'(t - {1'b0, d})};
    end
    return {1'b0, t[31:0]};
  endfunction

  // Q30 factor 2^-(2^-idx), built by repeated integer square roots
  function automatic logic [30:0] exp_coef(int idx);
    longint unsigned c;
    longint unsigned v;
    longint unsigned res;
    longint unsigned b;
    int k;
    int j;
    c = 64'd1 << 29;
    for (k = 1; k <= idx; k++) begin
      v   = c << 30;
      res = 0;
      b   = 64'd1 << 62;
      for (j = 0; j < 32; j++) begin
        if (v >= res + b) begin
          v   = v - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      c = res;
    end
    return c[30:0];
  endfunction

endpackage

### src/label_loss_gradient_hessian.sv
// ----------------------------------------------------------------------------
// label_loss_gradient_hessian
// Gradient and hessian of a per-label loss (logistic, squared error,
// squared hinge) for one label/score word per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
//  channel  dir  width         contents
//  s_axis   in   40 + tuser-   label and Q16 score
//  m_axis   out  56 + 1 tuser  gradient, hessian, saturation flag
//  apb      in   2-bit addr    loss_mode at address 0
//
// The pipe holds 16 exponent multiply stages, 30 divide steps for the
// logistic hessian ratio and 17 for its rounding.
// Reset clears the stage valid bits and loss_mode; no clearing pass.
// Stalls freeze the whole pipe; the input is taken whenever the output
// register is empty or being read.
module label_loss_gradient_hessian
  import llgh_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,   // [0] true_label, [32:1] predicted_score
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [55:0] m_axis_tdata_o,   // [31:0] gradient, [49:32] hessian
  output logic [0:0]  m_axis_tuser_o,   // [0] saturated
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [1:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o
);

  localparam int NCTL = 66;

  logic en;
  loss_mode_e mode_q;

  logic        vld_q [NCTL];
  ctl_t        ctl_q [NCTL];
  ctl_t        ctl_in;
  logic [20:0] a21_q, a21_d;
  logic        big_q, big_d;
  exp_t        exp_q [EXP_STEPS+1];
  exp_t        exp_d [EXP_STEPS+1];
  div_t        div_q [P_BITS+1];
  div_t        div_d [P_BITS+1];
  hdiv_t       hd_q  [R_BITS+1];
  hdiv_t       hd_d  [R_BITS+1];

  logic               out_vld_q;
  logic signed [31:0] grad_q, grad_d;
  logic [17:0]        hess_q, hess_d;
  logic               sat_q, sat_d;

  assign en              = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = en;

  // ---------------- configuration ----------------
  assign pready_o = 1'b1;
  assign prdata_o = ({30'd0, paddr_i} == CFG_ADDR_LOSS_MODE) ? {30'd0, mode_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= LOSS_LOGISTIC;
    end else if (psel_i && penable_i && pwrite_i &&
                 {30'd0, paddr_i} == CFG_ADDR_LOSS_MODE) begin
      mode_q <= loss_mode_e'(pwdata_i[1:0]);
    end
  end

  // ---------------- stage A: alternate losses, |y*s| ----------------
  always_comb begin
    logic signed [31:0] s;
    logic signed [34:0] s2;
    logic signed [34:0] g;
    logic signed [32:0] x;
    logic [32:0]        a;
    logic               pos;
    s   = $signed(s_axis_tdata_i[32:1]);
    pos = s_axis_tdata_i[0];
    s2  = 35'(s) <<< 1;
    g   = '0;
    ctl_in.h_alt = '0;
    case (mode_q)
      LOSS_SQERR: begin
        g = pos ? s2 - 35'sd131072 : s2 + 35'sd131072;
        ctl_in.h_alt = 18'd131072;
      end
      LOSS_SQHINGE: begin
        if (pos && s < 32'sd65536) begin
          g = s2 - 35'sd131072;
          ctl_in.h_alt = 18'd131072;
        end else if (!pos && s > 32'sd0) begin
          g = s2;
          ctl_in.h_alt = 18'd131072;
        end
      end
      default: g = '0;
    endcase
    if (g > 35'sd2147483647) begin
      ctl_in.g_alt   = 32'sh7fff_ffff;
      ctl_in.sat_alt = 1'b1;
    end else if (g < -35'sd2147483648) begin
      ctl_in.g_alt   = 32'sh8000_0000;
      ctl_in.sat_alt = 1'b1;
    end else begin
      ctl_in.g_alt   = g[31:0];
      ctl_in.sat_alt = 1'b0;
    end
    x = pos ? 33'(s) : -33'(s);
    a = x[32] ? 33'(-x) : 33'(x);
    ctl_in.mode = mode_q;
    ctl_in.pos  = pos;
    ctl_in.xneg = x[32];
    // e^-a underflows to zero well below 2^21
    big_d = a[32:21] != '0;
    a21_d = a[20:0];
  end

  // ---------------- stage B: scale by log2(e) ----------------
  always_comb begin
    logic [51:0] u;
    u = 52'(a21_q) * 52'(LOG2E_Q30);
    exp_d[0].ez = big_q || u[51];
    exp_d[0].n  = u[50:46];
    exp_d[0].fb = u[45:30];
    exp_d[0].m  = Q30_ONE;
  end

  // ---------------- exponent: one factor per stage ----------------
  for (genvar i = 1; i <= EXP_STEPS; i++) begin : g_exp
    localparam logic [30:0] C = exp_coef(i);
    logic [61:0] prod;
    always_comb begin
      prod     = 62'(exp_q[i-1].m) * 62'(C);
      exp_d[i] = exp_q[i-1];
      if (exp_q[i-1].fb[EXP_STEPS-i]) begin
        exp_d[i].m = prod[60:30];
      end
    end
  end

  // ---------------- divide setup ----------------
  always_comb begin
    logic [30:0] e;
    logic [31:0] d;
    logic [30:0] num;
    logic [46:0] nr;
    e   = exp_q[EXP_STEPS].ez ? 31'd0 : exp_q[EXP_STEPS].m >> exp_q[EXP_STEPS].n;
    d   = {1'b0, Q30_ONE} + {1'b0, e};
    num = ctl_q[17].xneg ? Q30_ONE : e;
    nr  = {num, 16'd0} + 47'(d >> 1);
    div_d[0].d   = d;
    div_d[0].pr  = {1'b0, e};
    div_d[0].pq  = '0;
    div_d[0].rr  = {2'b00, nr[46:17]};
    div_d[0].rq  = '0;
    div_d[0].rlo = nr[16:0];
  end

  // p = E*2^30/D in all steps, rounded gradient ratio in the first 17
  for (genvar k = 1; k <= P_BITS; k++) begin : g_div
    logic [32:0] sp;
    logic [32:0] sr;
    always_comb begin
      sp = div_step(div_q[k-1].pr, 1'b0, div_q[k-1].d);
      sr = div_step(div_q[k-1].rr, div_q[k-1].rlo[R_BITS-1], div_q[k-1].d);
      div_d[k]    = div_q[k-1];
      div_d[k].pr = sp[31:0];
      div_d[k].pq = {div_q[k-1].pq[P_BITS-2:0], sp[32]};
      if (k <= R_BITS) begin
        div_d[k].rr  = sr[31:0];
        div_d[k].rq  = {div_q[k-1].rq[R_BITS-2:0], sr[32]};
        div_d[k].rlo = {div_q[k-1].rlo[R_BITS-2:0], 1'b0};
      end
    end
  end

  // rounded hessian divide
  always_comb begin
    logic [46:0] nh;
    nh = {1'b0, div_q[P_BITS].pq, 16'd0} + 47'(div_q[P_BITS].d >> 1);
    hd_d[0].d   = div_q[P_BITS].d;
    hd_d[0].rem = {2'b00, nh[46:17]};
    hd_d[0].q   = '0;
    hd_d[0].lo  = nh[16:0];
    hd_d[0].r   = div_q[P_BITS].rq;
  end

  // stage 0 of the hessian divide is folded into step 1
  for (genvar j = 1; j <= R_BITS; j++) begin : g_hdiv
    logic [32:0] sh;
    hdiv_t       src;
    always_comb begin
      src        = (j == 1) ? hd_d[0] : hd_q[j-1];
      sh         = div_step(src.rem, src.lo[R_BITS-1], src.d);
      hd_d[j]     = src;
      hd_d[j].rem = sh[31:0];
      hd_d[j].q   = {src.q[R_BITS-2:0], sh[32]};
      hd_d[j].lo  = {src.lo[R_BITS-2:0], 1'b0};
    end
  end

  // ---------------- output select ----------------
  always_comb begin
    if (ctl_q[NCTL-1].mode == LOSS_LOGISTIC) begin
      grad_d = ctl_q[NCTL-1].pos ? -$signed({15'd0, hd_q[R_BITS].r})
                                 :  $signed({15'd0, hd_q[R_BITS].r});
      hess_d = {1'b0, hd_q[R_BITS].q};
      sat_d  = 1'b0;
    end else begin
      grad_d = ctl_q[NCTL-1].g_alt;
      hess_d = ctl_q[NCTL-1].h_alt;
      sat_d  = ctl_q[NCTL-1].sat_alt;
    end
  end

  // ---------------- pipeline registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NCTL; k++) begin
        vld_q[k] <= 1'b0;
      end
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q[0] <= s_axis_tvalid_i;
      for (int k = 1; k < NCTL; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
      out_vld_q <= vld_q[NCTL-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ctl_q[0] <= ctl_in;
      for (int k = 1; k < NCTL; k++) begin
        ctl_q[k] <= ctl_q[k-1];
      end
      a21_q <= a21_d;
      big_q <= big_d;
      for (int k = 0; k <= EXP_STEPS; k++) begin
        exp_q[k] <= exp_d[k];
      end
      for (int k = 0; k <= P_BITS; k++) begin
        div_q[k] <= div_d[k];
      end
      for (int k = 0; k <= R_BITS; k++) begin
        hd_q[k] <= hd_d[k];
      end
      grad_q <= grad_d;
      hess_q <= hess_d;
      sat_q  <= sat_d;
    end
  end

  assign m_axis_tvalid_o   = out_vld_q;
  assign m_axis_tdata_o    = {6'd0, hess_q, grad_q};
  assign m_axis_tuser_o[0] = sat_q;

  // ---------------- assertions ----------------
  a_sat_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[0]) |->
      (m_axis_tdata_o[31:0] == 32'h7fff_ffff || m_axis_tdata_o[31:0] == 32'h8000_0000))
    else $error("saturated word without a clipped gradient");

  a_hess_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[49:32] <= 18'd131072))
    else $error("hessian above 2.0");

  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |-> !s_axis_tready_o)
    else $error("input taken while output stalled");

endmodule
